>>> rtl/cns_pkg.sv
// cns_pkg: shared types, codes and defaults for the cluster node selector
// used by cluster_node_selector; depends on nothing
`default_nettype none
package cns_pkg;

   localparam int NODES_DEF      = 16;
   localparam int MODEL_BITS_DEF = 16;
   localparam logic [15:0] MISS_SCORE = 16'd1000;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_UPDATE = 3'd2,
      OP_HEALTH = 3'd3,
      OP_TICK   = 3'd4,
      OP_SELECT = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      STRAT_RR      = 3'd0,
      STRAT_LOAD    = 3'd1,
      STRAT_CAP     = 3'd2,
      STRAT_LATENCY = 3'd3,
      STRAT_MODEL   = 3'd4
   } strat_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   localparam logic [2:0] HEALTH_HEALTHY = 3'd1;
   localparam logic [2:0] HEALTH_DOWN    = 3'd3;

   localparam logic [1:0] REG_STRATEGY = 2'd0;
   localparam logic [1:0] REG_TIMEOUT  = 2'd1;

   localparam logic [2:0] STRATEGY_RESET = 3'd1;
   localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_SCAN,
      S_ACT,
      S_SHIFT
   } state_type;

   // fixed-width part of one table entry, model set is stored next to it
   typedef struct packed {
      logic [15:0] key;
      logic [31:0] caps;
      logic [7:0]  limit;
      logic [7:0]  load;
      logic [2:0]  health;
      logic [15:0] latency;
      logic [31:0] last_seen;
   } entry_type;

endpackage
`default_nettype wire

>>> rtl/cns_mem.sv
// cns_mem: node table storage, one write port and one registered read port
// depends on nothing
`default_nettype none
module cns_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 131
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> rtl/cns_rem.sv
// cns_rem: bit-serial restoring remainder, one dividend bit per cycle
// depends on nothing
`default_nettype none
module cns_rem #(
   parameter int W  = 32,
   parameter int DW = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [W-1:0]  dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic      [DW-1:0] remainder
);

   localparam int CNTW = $clog2(W + 1);

   logic [W-1:0]    sh_ff, sh_in;
   logic [DW:0]     rem_ff, rem_in;
   logic [DW-1:0]   div_ff, div_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [DW:0]     trial;

   always_comb begin
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DW-1:0], sh_ff[W-1]};
      if (start) begin
         sh_in  = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNTW'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         sh_in = {sh_ff[W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[DW-1:0];

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < {1'b0, div_ff}))
      else $error("remainder not below divisor");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("remainder done while still running");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(run_ff) && !$past(start) |-> done_ff)
      else $error("remainder run ended without done");

endmodule
`default_nettype wire

>>> rtl/cluster_node_selector.sv
// cluster_node_selector: top level, operation sequencer around the node table
// depends on cns_pkg, cns_mem and cns_rem
//
//   channel   ports                         transfer when
//   request   req_start, req_* fields      req_start high and busy low
//   response  rsp_valid, rsp_* fields      rsp_valid high (one cycle, no stall)
//   config    csr_we, csr_index, csr_wdata  csr_we high
//
// table walk: every operation walks the table once, one entry a cycle through the
// memory read port, and busy stays high until the operation has finished
// round-robin select on a non-empty table first runs the remainder unit
// remove of a found entry then shifts the later entries down, one per cycle
// reset empties the table at once (entry count to zero), no clearing pass
// the response is a one-cycle strobe and the receiver cannot hold it off
`default_nettype none
module cluster_node_selector #(
   parameter int NODES      = cns_pkg::NODES_DEF,
   parameter int MODEL_BITS = cns_pkg::MODEL_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [15:0] req_node_key,
   input  wire logic [31:0] req_cap_mask,
   input  wire logic [7:0]  req_limit_value,
   input  wire logic [7:0]  req_load_value,
   input  wire logic [2:0]  req_health_value,
   input  wire logic [15:0] req_latency_value,
   input  wire logic [15:0] req_model_set,
   input  wire logic [3:0]  req_model_number,
   input  wire logic [31:0] req_now_time,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_slot_index,
   output logic [15:0]      rsp_chosen_key,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int IW = $clog2(NODES);
   localparam int CW = $clog2(NODES + 1);
   localparam int FW = $bits(cns_pkg::entry_type);
   localparam int DW = FW + MODEL_BITS;

   // state and latched request
   cns_pkg::state_type state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [15:0] key_ff, key_in;
   logic [31:0] caps_ff, caps_in;
   logic [7:0]  limit_ff, limit_in;
   logic [7:0]  load_ff, load_in;
   logic [2:0]  health_ff, health_in;
   logic [15:0] lat_ff, lat_in;
   logic [MODEL_BITS-1:0] mset_ff, mset_in;
   logic [3:0]  modnum_ff, modnum_in;
   logic [31:0] now_ff, now_in;

   // block state
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   rot_ff, rot_in;
   logic [2:0]    strat_ff;
   logic [31:0]   tmo_ff;

   // table walk
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic          found_ff, found_in;
   logic [IW-1:0] found_idx_ff, found_idx_in;
   cns_pkg::entry_type rec_ff, rec_in;
   logic [MODEL_BITS-1:0] recm_ff, recm_in;
   logic [15:0]   best_ff, best_in;
   logic [IW-1:0] rr_ff, rr_in;

   // response
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic [15:0] rsp_key_ff, rsp_key_in;

   // memory and remainder unit
   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [DW-1:0] mem_wdata, mem_rdata;
   cns_pkg::entry_type rd_rec, new_rec;
   logic [MODEL_BITS-1:0] rd_mod;
   logic          rem_start, rem_done;
   logic [CW-1:0] rem_value;

   // per-entry scoring
   logic [63:0] mset_wide, rd_mod_wide;
   logic [5:0]  pop;
   logic [31:0] xor_caps;
   logic        eligible, timed_out;
   logic [15:0] score;
   logic [7:0]  slot8;

   cns_mem #(.DEPTH(NODES), .AW(IW), .DW(DW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   cns_rem #(.W(32), .DW(CW)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rot_ff),
      .divisor   (count_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign rd_rec    = cns_pkg::entry_type'(mem_rdata[FW-1:0]);
   assign rd_mod    = mem_rdata[DW-1:FW];
   assign mset_wide = 64'(req_model_set);

   always_comb begin
      rd_mod_wide = '0;
      rd_mod_wide[MODEL_BITS-1:0] = rd_mod;
   end

   // popcount of capability mismatch
   always_comb begin
      xor_caps = rd_rec.caps ^ caps_ff;
      pop = '0;
      for (int b = 0; b < 32; b++) begin
         pop = pop + 6'(xor_caps[b]);
      end
   end

   assign eligible = (rd_rec.health == cns_pkg::HEALTH_HEALTHY)
                  && ((rd_rec.caps & caps_ff) == caps_ff)
                  && (rd_rec.load < rd_rec.limit);
   assign timed_out = (rd_rec.health == cns_pkg::HEALTH_HEALTHY)
                   && ((now_ff - rd_rec.last_seen) > tmo_ff);

   always_comb begin
      case (strat_ff)
         cns_pkg::STRAT_RR:      score = 16'(rr_ff);
         cns_pkg::STRAT_LOAD:    score = 16'(rd_rec.load);
         cns_pkg::STRAT_CAP:     score = 16'(pop);
         cns_pkg::STRAT_LATENCY: score = rd_rec.latency;
         cns_pkg::STRAT_MODEL:   score = rd_mod_wide[modnum_ff] ? 16'd0 : cns_pkg::MISS_SCORE;
         default:                score = 16'd0;
      endcase
   end

   // entry built from the latched request
   always_comb begin
      new_rec.key       = key_ff;
      new_rec.caps      = caps_ff;
      new_rec.limit     = limit_ff;
      new_rec.load      = load_ff;
      new_rec.health    = health_ff;
      new_rec.latency   = lat_ff;
      new_rec.last_seen = now_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      caps_in      = caps_ff;
      limit_in     = limit_ff;
      load_in      = load_ff;
      health_in    = health_ff;
      lat_in       = lat_ff;
      mset_in      = mset_ff;
      modnum_in    = modnum_ff;
      now_in       = now_ff;
      count_in     = count_ff;
      rot_in       = rot_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      rec_in       = rec_ff;
      recm_in      = recm_ff;
      best_in      = best_ff;
      rr_in        = rr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      mem_we    = 1'b0;
      mem_waddr = pend_idx_ff;
      mem_wdata = mem_rdata;
      mem_raddr = rd_idx_ff[IW-1:0];
      rem_start = 1'b0;
      slot8     = 8'(found_idx_ff);

      case (state_ff)
         cns_pkg::S_IDLE: begin
            if (req_start) begin
               op_in     = req_operation;
               key_in    = req_node_key;
               caps_in   = req_cap_mask;
               limit_in  = req_limit_value;
               load_in   = req_load_value;
               health_in = req_health_value;
               lat_in    = req_latency_value;
               mset_in   = mset_wide[MODEL_BITS-1:0];
               modnum_in = req_model_number;
               now_in    = req_now_time;
               rd_idx_in = '0;
               found_in  = 1'b0;
               if (req_operation == cns_pkg::OP_SELECT && strat_ff == cns_pkg::STRAT_RR
                   && count_ff != '0) begin
                  rem_start = 1'b1;
                  state_in  = cns_pkg::S_DIV;
               end else begin
                  state_in = cns_pkg::S_SCAN;
               end
            end
         end

         cns_pkg::S_DIV: begin
            if (rem_done) begin
               rr_in    = rem_value[IW-1:0];
               state_in = cns_pkg::S_SCAN;
            end
         end

         cns_pkg::S_SCAN: begin
            if (rd_idx_ff < count_ff) begin
               rd_idx_in   = rd_idx_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[IW-1:0];
            end else if (!pend_ff) begin
               state_in = cns_pkg::S_ACT;
            end
            if (pend_ff) begin
               case (op_ff)
                  cns_pkg::OP_ADD, cns_pkg::OP_REMOVE,
                  cns_pkg::OP_UPDATE, cns_pkg::OP_HEALTH: begin
                     if (!found_ff && rd_rec.key == key_ff) begin
                        found_in     = 1'b1;
                        found_idx_in = pend_idx_ff;
                        rec_in       = rd_rec;
                        recm_in      = rd_mod;
                     end
                  end
                  cns_pkg::OP_TICK: begin
                     if (timed_out) begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_mod, rd_rec.key, rd_rec.caps, rd_rec.limit,
                                     rd_rec.load, cns_pkg::HEALTH_DOWN, rd_rec.latency,
                                     rd_rec.last_seen};
                     end
                  end
                  cns_pkg::OP_SELECT: begin
                     if (eligible) begin
                        if (strat_ff == cns_pkg::STRAT_RR) begin
                           rot_in = rot_ff + 32'd1;
                           if (CW'(rr_ff) + 1'b1 == count_ff) begin
                              rr_in = '0;
                           end else begin
                              rr_in = rr_ff + 1'b1;
                           end
                        end
                        if (!found_ff || score < best_ff) begin
                           found_in     = 1'b1;
                           found_idx_in = pend_idx_ff;
                           best_in      = score;
                           rec_in       = rd_rec;
                           recm_in      = rd_mod;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         cns_pkg::S_ACT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cns_pkg::ST_OK;
            rsp_slot_in   = 4'd0;
            rsp_key_in    = 16'd0;
            state_in      = cns_pkg::S_IDLE;
            case (op_ff)
               cns_pkg::OP_ADD: begin
                  if (count_ff >= CW'(NODES)) begin
                     rsp_status_in = cns_pkg::ST_FULL;
                  end else if (found_ff) begin
                     rsp_status_in = cns_pkg::ST_DUPLICATE;
                     rsp_slot_in   = slot8[3:0];
                  end else begin
                     mem_we      = 1'b1;
                     mem_waddr   = count_ff[IW-1:0];
                     mem_wdata   = {mset_ff, new_rec};
                     slot8       = 8'(count_ff);
                     rsp_slot_in = slot8[3:0];
                     count_in    = count_ff + 1'b1;
                  end
               end
               cns_pkg::OP_REMOVE: begin
                  if (!found_ff) begin
                     rsp_status_in = cns_pkg::ST_NOT_FOUND;
                  end else begin
                     // shift the later entries down before answering
                     rsp_valid_in = 1'b0;
                     rd_idx_in    = CW'(found_idx_ff) + 1'b1;
                     state_in     = cns_pkg::S_SHIFT;
                  end
               end
               cns_pkg::OP_UPDATE: begin
                  if (!found_ff) begin
                     rsp_status_in = cns_pkg::ST_NOT_FOUND;
                  end else begin
                     mem_we      = 1'b1;
                     mem_waddr   = found_idx_ff;
                     mem_wdata   = {mset_ff, new_rec};
                     rsp_slot_in = slot8[3:0];
                  end
               end
               cns_pkg::OP_HEALTH: begin
                  if (!found_ff) begin
                     rsp_status_in = cns_pkg::ST_NOT_FOUND;
                  end else begin
                     mem_we      = 1'b1;
                     mem_waddr   = found_idx_ff;
                     mem_wdata   = {recm_ff, rec_ff.key, rec_ff.caps, rec_ff.limit,
                                    rec_ff.load, health_ff, rec_ff.latency,
                                    rec_ff.last_seen};
                     rsp_slot_in = slot8[3:0];
                  end
               end
               cns_pkg::OP_SELECT: begin
                  if (!found_ff) begin
                     rsp_status_in = cns_pkg::ST_NOT_FOUND;
                  end else begin
                     // winner takes one more request
                     mem_we      = 1'b1;
                     mem_waddr   = found_idx_ff;
                     mem_wdata   = {recm_ff, rec_ff.key, rec_ff.caps, rec_ff.limit,
                                    rec_ff.load + 8'd1, rec_ff.health, rec_ff.latency,
                                    rec_ff.last_seen};
                     rsp_slot_in = slot8[3:0];
                     rsp_key_in  = rec_ff.key;
                  end
               end
               default: begin
               end
            endcase
         end

         cns_pkg::S_SHIFT: begin
            if (rd_idx_ff < count_ff) begin
               rd_idx_in   = rd_idx_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[IW-1:0];
            end else if (!pend_ff) begin
               count_in      = count_ff - 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = cns_pkg::ST_OK;
               rsp_slot_in   = slot8[3:0];
               rsp_key_in    = 16'd0;
               state_in      = cns_pkg::S_IDLE;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_idx_ff - 1'b1;
               mem_wdata = mem_rdata;
            end
         end

         default: begin
            state_in = cns_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cns_pkg::S_IDLE;
         count_ff     <= '0;
         rot_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         strat_ff     <= cns_pkg::STRATEGY_RESET;
         tmo_ff       <= cns_pkg::TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rot_ff       <= rot_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == cns_pkg::REG_STRATEGY) begin
            strat_ff <= csr_wdata[2:0];
         end
         if (csr_we && csr_index == cns_pkg::REG_TIMEOUT) begin
            tmo_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      caps_ff       <= caps_in;
      limit_ff      <= limit_in;
      load_ff       <= load_in;
      health_ff     <= health_in;
      lat_ff        <= lat_in;
      mset_ff       <= mset_in;
      modnum_ff     <= modnum_in;
      now_ff        <= now_in;
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      found_idx_ff  <= found_idx_in;
      rec_ff        <= rec_in;
      recm_ff       <= recm_in;
      best_ff       <= best_in;
      rr_ff         <= rr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign busy           = (state_ff != cns_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_chosen_key = rsp_key_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NODES))
      else $error("entry count beyond table depth");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == cns_pkg::S_ACT || $past(state_ff) == cns_pkg::S_SHIFT)
      else $error("response without finished operation");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == cns_pkg::S_IDLE)
      else $error("sequencer not idle after response");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> CW'(mem_waddr) <= count_ff)
      else $error("table write beyond filled entries");

endmodule
`default_nettype wire
